// ===== rtl/bdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants of the debounced button press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

  localparam int unsigned HoldWidthDefault = 16;
  localparam int unsigned RunWidth         = 4;
  localparam int unsigned ThrWidth         = 16;
  localparam int unsigned CfgIdxWidth      = 2;
  localparam int unsigned CfgDataWidth     = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxWidth-1:0] CfgActiveLow     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgDebounceTicks = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgShortTicks    = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgLongTicks     = 2'd3;

  // Reset values of the configuration registers.
  localparam logic                RstActiveLow     = 1'b0;
  localparam logic [RunWidth-1:0] RstDebounceTicks = 4'd5;
  localparam logic [ThrWidth-1:0] RstShortTicks    = 16'd10;
  localparam logic [ThrWidth-1:0] RstLongTicks     = 16'd1000;

  typedef enum logic [1:0] {
    ClassNone  = 2'd0,
    ClassShort = 2'd1,
    ClassLong  = 2'd2
  } class_e;

  // Debounced level before and after the tick being processed.
  typedef struct packed {
    logic prev;
    logic next;
  } level_t;

endpackage

`default_nettype wire

// ===== rtl/bdpc_debounce.sv =====
// ----------------------------------------------------------------------------
// bdpc_debounce
// Counter debouncer: a run of disagreeing samples that reaches the threshold
// flips the debounced level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_debounce
  import bdpc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic                sample_i,
  input  wire logic [RunWidth-1:0] debounce_ticks_i,
  output level_t                   level_o
);

  logic                level_q, level_d;
  logic [RunWidth-1:0] run_q, run_d;
  logic [RunWidth-1:0] run_inc;

  always_comb begin
    run_inc = (run_q == {RunWidth{1'b1}}) ? run_q : run_q + RunWidth'(1);
    level_d = level_q;
    run_d   = '0;
    if (sample_i != level_q) begin
      if (run_inc >= debounce_ticks_i) begin
        level_d = sample_i;
      end else begin
        run_d = run_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      run_q   <= '0;
    end else if (step_i) begin
      level_q <= level_d;
      run_q   <= run_d;
    end
  end

  assign level_o.prev = level_q;
  assign level_o.next = level_d;

  // A flip always starts a fresh run.
  a_flip_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (level_d != level_q) |=> run_q == '0)
    else $error("debounce run not cleared after a flip");

endmodule

`default_nettype wire

// ===== rtl/bdpc_classify.sv =====
// ----------------------------------------------------------------------------
// bdpc_classify
// Hold counter and short/long press classification on debounced edges.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_classify
  import bdpc_pkg::*;
#(
  parameter int unsigned HoldWidth = HoldWidthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire level_t              level_i,
  input  wire logic [ThrWidth-1:0] short_ticks_i,
  input  wire logic [ThrWidth-1:0] long_ticks_i,
  output class_e                   class_o,
  output logic                     changed_o
);

  localparam int unsigned CmpWidth = (HoldWidth > ThrWidth) ? HoldWidth : ThrWidth;

  logic [HoldWidth-1:0] hold_q, hold_d, hold_inc;
  class_e               class_q, class_d;
  logic                 rise, fall;
  logic                 is_long, is_short;

  // The press is active exactly while the debounced level is high, so the
  // previous level also serves as the press-active flag.
  assign rise = level_i.next && !level_i.prev;
  assign fall = !level_i.next && level_i.prev;

  always_comb begin
    hold_inc = (hold_q == {HoldWidth{1'b1}}) ? hold_q : hold_q + HoldWidth'(1);
    is_long  = CmpWidth'(hold_inc) >= CmpWidth'(long_ticks_i);
    is_short = CmpWidth'(hold_inc) >= CmpWidth'(short_ticks_i);
    hold_d   = hold_q;
    class_d  = class_q;
    if (rise) begin
      hold_d  = '0;
      class_d = ClassNone;
    end else if (fall) begin
      hold_d = hold_inc;
      if (is_long) begin
        class_d = ClassLong;
      end else if (is_short) begin
        class_d = ClassShort;
      end else begin
        class_d = ClassNone;
      end
    end else if (level_i.next) begin
      hold_d = hold_inc;
      if (is_long) begin
        class_d = ClassLong;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= '0;
      class_q <= ClassNone;
    end else if (step_i) begin
      hold_q  <= hold_d;
      class_q <= class_d;
    end
  end

  assign class_o   = class_d;
  assign changed_o = (class_d != class_q);

  a_press_clears_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && rise |=> class_q == ClassNone && hold_q == '0)
    else $error("press edge did not restart the classification");

  a_class_only_moves_on_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !level_i.next && !level_i.prev |=> $stable(class_q))
    else $error("class changed while the button stayed released");

endmodule

`default_nettype wire

// ===== rtl/button_debounce_press_classifier.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces a polled button pin and classifies each press as short, long or neither.
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid/in_ready    raw_level
//   out       output     out_valid/out_ready  press_class, pressed_now,
//                                             class_changed
//   cfg       input      cfg_we (no wait)     cfg_idx, cfg_wdata
//
// One poll sample is taken per cycle while the output is not stalled; its result
// passes through the input register, then the result register, before it is
// offered on the output.
// The state advances when a sample moves from the input register into the
// result register, which happens whenever the result register is empty or
// being taken in the same cycle.
// A stalled output holds the result register and then the input register.
// Reset loads the configuration defaults and a released, unclassified button.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_press_classifier
  import bdpc_pkg::*;
#(
  parameter int unsigned HOLD_WIDTH = HoldWidthDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    raw_level_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [1:0]                   press_class_o,
  output logic                         pressed_now_o,
  output logic                         class_changed_o
);

  logic                active_low_q;
  logic [RunWidth-1:0] debounce_ticks_q;
  logic [ThrWidth-1:0] short_ticks_q;
  logic [ThrWidth-1:0] long_ticks_q;

  logic   in_valid_q, raw_q;
  logic   out_valid_q;
  logic   out_changed_q, out_level_q;
  class_e out_class_q;

  logic   step;
  level_t level;
  class_e class_next;
  logic   changed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q     <= RstActiveLow;
      debounce_ticks_q <= RstDebounceTicks;
      short_ticks_q    <= RstShortTicks;
      long_ticks_q     <= RstLongTicks;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgActiveLow:     active_low_q     <= cfg_wdata_i[0];
        CfgDebounceTicks: debounce_ticks_q <= cfg_wdata_i[RunWidth-1:0];
        CfgShortTicks:    short_ticks_q    <= cfg_wdata_i[ThrWidth-1:0];
        CfgLongTicks:     long_ticks_q     <= cfg_wdata_i[ThrWidth-1:0];
        default: ;
      endcase
    end
  end

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      raw_q <= raw_level_i;
    end
  end

  bdpc_debounce u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .sample_i         (raw_q ^ active_low_q),
    .debounce_ticks_i (debounce_ticks_q),
    .level_o          (level)
  );

  bdpc_classify #(
    .HoldWidth (HOLD_WIDTH)
  ) u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .level_i       (level),
    .short_ticks_i (short_ticks_q),
    .long_ticks_i  (long_ticks_q),
    .class_o       (class_next),
    .changed_o     (changed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_class_q   <= class_next;
      out_level_q   <= level.next;
      out_changed_q <= changed;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign press_class_o   = out_class_q;
  assign pressed_now_o   = out_level_q;
  assign class_changed_o = out_changed_q;

  a_no_reserved_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_class_q != 2'd3)
    else $error("reserved press class on the output");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled although a stage was free");

endmodule

`default_nettype wire
